// File: rtl/fpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants of the fit policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

   localparam int NUM_BLOCKS_DEF = 16;

   localparam int SIZE_W      = 16;
   localparam int BLOCK_IDX_W = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int MODE_W      = 2;
   localparam int IN_USE_W    = 5;

   localparam logic [IN_USE_W-1:0] IN_USE_RESET = IN_USE_W'(16);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_IN_USE = 1'b1;

   // item kinds
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NEXT  = 2'd3
   } fit_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } fpba_state_type;

   typedef struct packed {
      logic capture;   // take the request word
      logic issue;     // read one table entry
      logic commit;    // write back and load the response word
   } fpba_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } fpba_status_type;

endpackage

// File: rtl/fpba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: accepts a word, walks the table scan for an allocate word, then commits the result.
// ----------------------------------------------------------------------------
module fpba_ctrl
   import fpba_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_func,
   output logic            req_stall,
   input  fpba_status_type status,
   output fpba_cmd_type    cmd
);

   fpba_state_type state_ff;
   fpba_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_func == FUNC_ALLOC) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            // last read data is compared in the cycle the count runs out
            if (!status.scan_done) begin
               cmd.issue = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/fpba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_dp
// Capacity table, scan pointer, fit compare, config and response registers.
// ----------------------------------------------------------------------------
module fpba_dp
   import fpba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_func,
   input  logic [BLOCK_IDX_W-1:0] req_block_index,
   input  logic [SIZE_W-1:0]      req_size,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   rsp_granted,
   output logic [BLOCK_IDX_W-1:0] rsp_chosen_block,
   output logic [SIZE_W-1:0]      rsp_remaining,
   input  fpba_cmd_type           cmd,
   output fpba_status_type        status
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   // config
   fit_mode_type              fit_mode_ff;
   logic [IN_USE_W-1:0]       blocks_in_use_ff;

   // table
   logic [SIZE_W-1:0]         mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0]     valid_ff;
   logic                      mem_we;
   logic [IDX_W-1:0]          mem_waddr;
   logic [SIZE_W-1:0]         mem_wdata;
   logic [SIZE_W-1:0]         rd_data_ff;
   logic                      rd_ok_ff;
   logic [IDX_W-1:0]          rd_idx_ff;
   logic                      rd_vld_ff;

   // scan
   logic                      is_alloc_ff;
   logic [SIZE_W-1:0]         size_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [CNT_W-1:0]          count_in_use;
   logic [CNT_W-1:0]          left_ff;
   logic [CNT_W-1:0]          left_in;
   logic [IDX_W-1:0]          ptr_ff;
   logic [IDX_W-1:0]          ptr_in;
   logic [IDX_W-1:0]          start_idx;
   logic                      found_ff;
   logic                      found_in;
   logic [SIZE_W-1:0]         best_cap_ff;
   logic [SIZE_W-1:0]         best_cap_in;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [IDX_W-1:0]          best_idx_in;
   logic [BLOCK_IDX_W-1:0]    last_ff;
   logic [SIZE_W-1:0]         cap;
   logic                      fits;
   logic                      take;
   logic                      granted;
   logic [SIZE_W-1:0]         left_cap;
   logic                      load_hit;

   // response register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      rsp_granted_ff;
   logic [BLOCK_IDX_W-1:0]    rsp_chosen_ff;
   logic [SIZE_W-1:0]         rsp_remaining_ff;

   // ---------------- config ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff      <= FIT_FIRST;
         blocks_in_use_ff <= IN_USE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_FIT_MODE) begin
            fit_mode_ff <= fit_mode_type'(csr_wr_data[MODE_W-1:0]);
         end
         if (csr_index == CSR_BLOCKS_IN_USE) begin
            blocks_in_use_ff <= csr_wr_data[IN_USE_W-1:0];
         end
      end
   end

   // ---------------- scan setup ----------------
   always_comb begin
      if (int'(blocks_in_use_ff) > NUM_BLOCKS) begin
         count_in_use = CNT_W'(NUM_BLOCKS);
      end else begin
         count_in_use = CNT_W'(blocks_in_use_ff);
      end
      // next fit resumes at the last grant when it is still in range
      if (fit_mode_ff == FIT_NEXT && int'(last_ff) < int'(count_in_use)) begin
         start_idx = IDX_W'(last_ff);
      end else begin
         start_idx = '0;
      end
   end

   always_comb begin
      left_in  = left_ff;
      ptr_in   = ptr_ff;
      count_in = count_ff;
      if (cmd.capture) begin
         count_in = count_in_use;
         left_in  = (req_func == FUNC_ALLOC) ? count_in_use : '0;
         ptr_in   = start_idx;
      end else if (cmd.issue) begin
         left_in = left_ff - CNT_W'(1);
         if (CNT_W'(ptr_ff) + CNT_W'(1) == count_ff) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + IDX_W'(1);
         end
      end
   end

   // ---------------- fit compare ----------------
   assign cap  = rd_ok_ff ? rd_data_ff : '0;
   assign fits = (cap >= size_ff);

   always_comb begin
      unique case (fit_mode_ff)
         FIT_FIRST: take = fits && !found_ff;
         FIT_NEXT:  take = fits && !found_ff;
         FIT_BEST:  take = fits && (!found_ff || cap <= best_cap_ff);
         FIT_WORST: take = fits && (!found_ff || cap >= best_cap_ff);
         default:   take = 1'b0;
      endcase
   end

   always_comb begin
      found_in    = found_ff;
      best_cap_in = best_cap_ff;
      best_idx_in = best_idx_ff;
      if (cmd.capture) begin
         found_in = 1'b0;
      end else if (rd_vld_ff && take) begin
         found_in    = 1'b1;
         best_cap_in = cap;
         best_idx_in = rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         left_ff   <= left_in;
         rd_vld_ff <= cmd.issue;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      ptr_ff      <= ptr_in;
      best_cap_ff <= best_cap_in;
      best_idx_ff <= best_idx_in;
      if (cmd.capture) begin
         is_alloc_ff <= (req_func == FUNC_ALLOC);
         size_ff     <= req_size;
      end
   end

   // ---------------- table ----------------
   assign granted  = is_alloc_ff && found_ff;
   assign left_cap = best_cap_ff - size_ff;
   assign load_hit = (req_func == FUNC_LOAD) && (int'(req_block_index) < NUM_BLOCKS);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = best_idx_ff;
      mem_wdata = left_cap;
      if (cmd.capture) begin
         mem_we    = load_hit;
         mem_waddr = IDX_W'(req_block_index);
         mem_wdata = req_size;
      end else if (cmd.commit) begin
         mem_we = granted;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[ptr_ff];
      rd_ok_ff   <= valid_ff[ptr_ff];
      rd_idx_ff  <= ptr_ff;
   end

   // unwritten entries read as zero capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[mem_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (cmd.commit && granted) begin
         last_ff <= BLOCK_IDX_W'(best_idx_ff);
      end
   end

   // ---------------- response ----------------
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_granted_ff   <= granted;
         rsp_chosen_ff    <= granted ? BLOCK_IDX_W'(best_idx_ff) : '0;
         rsp_remaining_ff <= granted ? left_cap : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_chosen_ff;
   assign rsp_remaining    = rsp_remaining_ff;

   assign status.scan_done = (left_ff == '0);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

// File: rtl/fit_policy_block_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top
// Fixed-block allocator with first, best, worst and next fit placement.
//
//   channel  direction  handshake             payload
//   req      in         req_valid / req_stall  req_func, req_block_index, req_size
//   rsp      out        rsp_valid / rsp_stall  rsp_granted, rsp_chosen_block,
//                                              rsp_remaining
//   csr      in         csr_wr_en              csr_index, csr_wr_data
//
// One word at a time. A load word skips the scan; an allocate word reads
// every block in use. The table has one read port and the scan reads one
// entry per cycle.
// Reset is synchronous; table entries read as zero until loaded, no clearing.
// A new word is taken while the previous response still waits; a stalled
// response holds the finished word before commit.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_top
   import fpba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [BLOCK_IDX_W-1:0] req_block_index,
   input  logic [SIZE_W-1:0]      req_size,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_granted,
   output logic [BLOCK_IDX_W-1:0] rsp_chosen_block,
   output logic [SIZE_W-1:0]      rsp_remaining
);

   fpba_cmd_type    cmd;
   fpba_status_type status;

   fpba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fpba_dp #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_func         (req_func),
      .req_block_index  (req_block_index),
      .req_size         (req_size),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_remaining    (rsp_remaining),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
